@@ sv/qbss_pkg.sv @@
// shared types, widths and codes for the quadratic bezier stroke segmenter
package qbss_pkg;

   localparam int COORD_BITS    = 16;
   localparam int MAX_SEGMENTS  = 64;
   localparam int LINE_W        = 8;
   localparam int SEG_REG_W     = 7;
   localparam logic [SEG_REG_W-1:0] SEG_RESET = SEG_REG_W'(50);

   // sample index runs 0..N, N^2 is the divisor
   localparam int IDX_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int SQ_W   = $clog2(MAX_SEGMENTS * MAX_SEGMENTS + 1);
   localparam int NUM_W  = COORD_BITS + SQ_W;
   localparam int MAG_W  = NUM_W - 1;
   localparam int QUO_W  = COORD_BITS;
   localparam int REM_W  = SQ_W + 1;
   localparam int STEP_W = $clog2(QUO_W);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_SEGMENT_COUNT = CSR_IDX_W'(0);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [LINE_W-1:0]            line_type;
   typedef logic [IDX_W-1:0]             idx_type;
   typedef logic [SQ_W-1:0]              sq_type;
   typedef logic [SEG_REG_W-1:0]         seg_type;

   typedef enum logic [1:0] {
      TERM_P0,
      TERM_P1,
      TERM_P2
   } term_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WEIGHT,
      ST_MAC0,
      ST_MAC1,
      ST_MAC2,
      ST_DIV_LOAD,
      ST_DIV,
      ST_FIX,
      ST_STEP
   } state_type;

   typedef struct packed {
      logic     load;
      logic     weights;
      logic     mac;
      term_type term;
      logic     div_load;
      logic     div_step;
      logic     fix;
      logic     advance;
      logic     emit;
      idx_type  index;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic last;
   } status_type;

endpackage

@@ sv/qbss_if.sv @@
// stream channel interfaces for stroke beats in and segment beats out
interface qbss_req_if;
   import qbss_pkg::*;
   logic      valid;
   logic      ready;
   coord_type first_x;
   coord_type first_y;
   coord_type middle_x;
   coord_type middle_y;
   coord_type final_x;
   coord_type final_y;
   line_type  line_width;

   modport source (
      output valid, first_x, first_y, middle_x, middle_y, final_x, final_y, line_width,
      input  ready
   );
   modport sink (
      input  valid, first_x, first_y, middle_x, middle_y, final_x, final_y, line_width,
      output ready
   );
endinterface

interface qbss_rsp_if;
   import qbss_pkg::*;
   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;
   line_type  width_out;
   logic      last_segment;

   modport source (
      output valid, start_x, start_y, end_x, end_y, width_out, last_segment,
      input  ready
   );
   modport sink (
      input  valid, start_x, start_y, end_x, end_y, width_out, last_segment,
      output ready
   );
endinterface

@@ sv/qbss_ctrl.sv @@
// sequencer: walks the sample index and the per-sample mac and divide steps
module qbss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  qbss_pkg::status_type status,
   output qbss_pkg::cmd_type    cmd
);
   import qbss_pkg::*;

   state_type          state_ff, state_in;
   idx_type            index_ff, index_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         index_ff <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         index_ff <= index_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_WEIGHT;
         ST_WEIGHT:   state_in = ST_MAC0;
         ST_MAC0:     state_in = ST_MAC1;
         ST_MAC1:     state_in = ST_MAC2;
         ST_MAC2:     state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = ST_DIV;
         ST_DIV:      if (step_ff == STEP_W'(QUO_W - 1)) state_in = ST_FIX;
         ST_FIX:      state_in = ST_STEP;
         ST_STEP: begin
            if (index_ff == '0) begin
               state_in = ST_WEIGHT;
            end else if (status.out_free) begin
               state_in = status.last ? ST_IDLE : ST_WEIGHT;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // counters
   always_comb begin
      index_in = index_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE:     index_in = '0;
         ST_DIV_LOAD: step_in = '0;
         ST_DIV:      step_in = step_ff + 1'b1;
         ST_STEP: begin
            if (index_ff == '0 || (status.out_free && !status.last)) begin
               index_in = index_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.term  = TERM_P0;
      cmd.index = index_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_WEIGHT:   cmd.weights = 1'b1;
         ST_MAC0: begin
            cmd.mac  = 1'b1;
            cmd.term = TERM_P0;
         end
         ST_MAC1: begin
            cmd.mac  = 1'b1;
            cmd.term = TERM_P1;
         end
         ST_MAC2: begin
            cmd.mac  = 1'b1;
            cmd.term = TERM_P2;
         end
         ST_DIV_LOAD: cmd.div_load = 1'b1;
         ST_DIV:      cmd.div_step = 1'b1;
         ST_FIX:      cmd.fix = 1'b1;
         ST_STEP: begin
            // first sample only seeds the previous point
            if (index_ff == '0) begin
               cmd.advance = 1'b1;
            end else if (status.out_free) begin
               cmd.advance = 1'b1;
               cmd.emit    = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

@@ sv/qbss_axis.sv @@
// one coordinate axis: control points, weighted sum and restoring divide by n^2
module qbss_axis (
   input  logic                clock,
   input  qbss_pkg::cmd_type   cmd,
   input  qbss_pkg::coord_type a,
   input  qbss_pkg::coord_type b,
   input  qbss_pkg::coord_type c,
   input  qbss_pkg::sq_type    w,
   input  qbss_pkg::sq_type    d,
   output qbss_pkg::coord_type point
);
   import qbss_pkg::*;

   coord_type               p0_ff, p0_in;
   coord_type               p1_ff, p1_in;
   coord_type               p2_ff, p2_in;
   logic signed [NUM_W-1:0] acc_ff, acc_in;
   logic                    neg_ff, neg_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   coord_type               point_ff, point_in;

   logic signed [COORD_BITS:0] sum_ab, sum_bc, adj_ab, adj_bc;
   coord_type                  p_sel;
   logic signed [NUM_W-1:0]    prod;
   logic [MAG_W-1:0]           mag;
   logic [REM_W-1:0]           trial;
   logic                       fits;

   // halving truncates toward zero: add one before the shift when negative
   assign sum_ab = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
   assign sum_bc = {b[COORD_BITS-1], b} + {c[COORD_BITS-1], c};
   assign adj_ab = sum_ab + {{COORD_BITS{1'b0}}, sum_ab[COORD_BITS]};
   assign adj_bc = sum_bc + {{COORD_BITS{1'b0}}, sum_bc[COORD_BITS]};

   always_comb begin
      case (cmd.term)
         TERM_P0: p_sel = p0_ff;
         TERM_P1: p_sel = p1_ff;
         TERM_P2: p_sel = p2_ff;
         default: p_sel = p0_ff;
      endcase
   end

   assign prod  = $signed({1'b0, w}) * p_sel;
   assign mag   = acc_ff[NUM_W-1] ? MAG_W'(-acc_ff) : MAG_W'(acc_ff);
   assign trial = {rem_ff[REM_W-2:0], quo_ff[QUO_W-1]};
   assign fits  = trial >= {1'b0, d};

   always_comb begin
      p0_in    = p0_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      point_in = point_ff;
      if (cmd.load) begin
         p0_in = adj_ab[COORD_BITS:1];
         p1_in = b;
         p2_in = adj_bc[COORD_BITS:1];
      end
      if (cmd.mac) begin
         acc_in = (cmd.term == TERM_P0) ? prod : acc_ff + prod;
      end
      if (cmd.div_load) begin
         // |num| < n^2 * 2^QUO_W, so the high part starts below the divisor
         neg_in = acc_ff[NUM_W-1];
         rem_in = REM_W'(mag[MAG_W-1:QUO_W]);
         quo_in = mag[QUO_W-1:0];
      end
      if (cmd.div_step) begin
         rem_in = fits ? trial - {1'b0, d} : trial;
         quo_in = {quo_ff[QUO_W-2:0], fits};
      end
      if (cmd.fix) begin
         point_in = neg_ff ? coord_type'(~quo_ff + 1'b1) : coord_type'(quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      p0_ff    <= p0_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      acc_ff   <= acc_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      point_ff <= point_in;
   end

   assign point = point_ff;

endmodule

@@ sv/qbss_datapath.sv @@
// datapath: segment count, bernstein weights, two axis units, output register
module qbss_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  qbss_pkg::cmd_type    cmd,
   output qbss_pkg::status_type status,
   input  qbss_pkg::seg_type    seg_count,
   input  qbss_pkg::coord_type  first_x,
   input  qbss_pkg::coord_type  first_y,
   input  qbss_pkg::coord_type  middle_x,
   input  qbss_pkg::coord_type  middle_y,
   input  qbss_pkg::coord_type  final_x,
   input  qbss_pkg::coord_type  final_y,
   input  qbss_pkg::line_type   line_width,
   qbss_rsp_if.source           rsp_ch
);
   import qbss_pkg::*;

   idx_type   n_ff, n_in;
   sq_type    d_ff, d_in;
   line_type  width_ff, width_in;
   sq_type    w0_ff, w0_in;
   sq_type    w1_ff, w1_in;
   sq_type    w2_ff, w2_in;
   coord_type prev_x_ff, prev_x_in;
   coord_type prev_y_ff, prev_y_in;
   coord_type out_sx_ff, out_sx_in;
   coord_type out_sy_ff, out_sy_in;
   coord_type out_ex_ff, out_ex_in;
   coord_type out_ey_ff, out_ey_in;
   line_type  out_w_ff, out_w_in;
   logic      out_last_ff, out_last_in;
   logic      out_valid_ff, out_valid_in;

   idx_type              n_eff, r;
   logic [2*IDX_W-1:0]   nn_full, rr_full, ir_full, ii_full;
   sq_type               w_sel;
   coord_type            point_x, point_y;

   // zero runs as one segment, large counts saturate
   always_comb begin
      if (seg_count == '0) begin
         n_eff = IDX_W'(1);
      end else if (seg_count > SEG_REG_W'(MAX_SEGMENTS)) begin
         n_eff = IDX_W'(MAX_SEGMENTS);
      end else begin
         n_eff = IDX_W'(seg_count);
      end
   end

   assign nn_full = n_eff * n_eff;
   assign r       = n_ff - cmd.index;
   assign rr_full = r * r;
   assign ir_full = cmd.index * r;
   assign ii_full = cmd.index * cmd.index;

   always_comb begin
      case (cmd.term)
         TERM_P0: w_sel = w0_ff;
         TERM_P1: w_sel = w1_ff;
         TERM_P2: w_sel = w2_ff;
         default: w_sel = w0_ff;
      endcase
   end

   qbss_axis u_axis_x (
      .clock (clock),
      .cmd   (cmd),
      .a     (first_x),
      .b     (middle_x),
      .c     (final_x),
      .w     (w_sel),
      .d     (d_ff),
      .point (point_x)
   );

   qbss_axis u_axis_y (
      .clock (clock),
      .cmd   (cmd),
      .a     (first_y),
      .b     (middle_y),
      .c     (final_y),
      .w     (w_sel),
      .d     (d_ff),
      .point (point_y)
   );

   assign status.out_free = !out_valid_ff || rsp_ch.ready;
   assign status.last     = (cmd.index == n_ff);

   always_comb begin
      n_in         = n_ff;
      d_in         = d_ff;
      width_in     = width_ff;
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      out_sx_in    = out_sx_ff;
      out_sy_in    = out_sy_ff;
      out_ex_in    = out_ex_ff;
      out_ey_in    = out_ey_ff;
      out_w_in     = out_w_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff;
      if (cmd.load) begin
         n_in     = n_eff;
         d_in     = SQ_W'(nn_full);
         width_in = line_width;
      end
      if (cmd.weights) begin
         w0_in = SQ_W'(rr_full);
         w1_in = SQ_W'({ir_full, 1'b0});
         w2_in = SQ_W'(ii_full);
      end
      if (cmd.advance) begin
         prev_x_in = point_x;
         prev_y_in = point_y;
      end
      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         out_sx_in    = prev_x_ff;
         out_sy_in    = prev_y_ff;
         out_ex_in    = point_x;
         out_ey_in    = point_y;
         out_w_in     = width_ff;
         out_last_in  = status.last;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         width_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         width_ff     <= width_in;
      end
      n_ff        <= n_in;
      d_ff        <= d_in;
      w0_ff       <= w0_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      out_sx_ff   <= out_sx_in;
      out_sy_ff   <= out_sy_in;
      out_ex_ff   <= out_ex_in;
      out_ey_ff   <= out_ey_in;
      out_w_ff    <= out_w_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.start_x      = out_sx_ff;
   assign rsp_ch.start_y      = out_sy_ff;
   assign rsp_ch.end_x        = out_ex_ff;
   assign rsp_ch.end_y        = out_ey_ff;
   assign rsp_ch.width_out    = out_w_ff;
   assign rsp_ch.last_segment = out_last_ff;

endmodule

@@ sv/quadratic_bezier_stroke_segmenter.sv @@
// top level: quadratic bezier stroke segmenter with register port
//
//  channel  direction  beat
//  req_ch   in         three stroke points and a line width
//  rsp_ch   out        one line segment, width and last flag
//  csr_*    in/out     apb-style access to segment_count at byte 0
//
// every sample point runs weights, three mac steps, divide load,
// one quotient bit per cycle over the 16-bit quotient, sign fix and step.
// an item of n segments walks n+1 sample points.
// rsp stalls hold the sequencer in its step state; the output register lets a
// new item be taken while the last segment still waits.
// reset is synchronous and sets segment_count to 50.
module quadratic_bezier_stroke_segmenter (
   input  logic                                 clock,
   input  logic                                 reset,
   qbss_req_if.sink                             req_ch,
   qbss_rsp_if.source                           rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [qbss_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [qbss_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [qbss_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import qbss_pkg::*;

   seg_type                seg_count_ff, seg_count_in;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic                   csr_write;
   cmd_type                cmd;
   status_type             status;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      seg_count_in = seg_count_ff;
      if (csr_write && csr_index == REG_SEGMENT_COUNT) begin
         seg_count_in = csr_pwdata[SEG_REG_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SEGMENT_COUNT: csr_prdata = CSR_DATA_W'(seg_count_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= SEG_RESET;
      end else begin
         seg_count_ff <= seg_count_in;
      end
   end

   qbss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   qbss_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .seg_count  (seg_count_ff),
      .first_x    (req_ch.first_x),
      .first_y    (req_ch.first_y),
      .middle_x   (req_ch.middle_x),
      .middle_y   (req_ch.middle_y),
      .final_x    (req_ch.final_x),
      .final_y    (req_ch.final_y),
      .line_width (req_ch.line_width),
      .rsp_ch     (rsp_ch)
   );

endmodule

@@ dv/qbss_segment_checker.sv @@
// scoreboard for the stroke segmenter: tracks segment_count, predicts segment beats, compares
`timescale 1ns / 1ps
module qbss_segment_checker (
   input  logic                            clock,
   input  logic                            reset,
   qbss_req_if                             req_ch,
   qbss_rsp_if                             rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic                            csr_pready,
   input  logic [qbss_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [qbss_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                              mismatch_count,
   output int                              segments_due
);
   import qbss_pkg::*;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      line_type  width;
      logic      last;
   } segment_type;

   seg_type     segment_count_q;
   segment_type pending_segments[$];

   initial begin
      mismatch_count = 0;
      segments_due   = 0;
   end

   function automatic longint halve_sum(input longint a, input longint b);
      return (a + b) / 2;
   endfunction

   // exact bernstein sample, signed division truncates toward zero
   function automatic coord_type curve_sample(input longint p0, input longint p1,
                                              input longint p2, input longint n,
                                              input longint i);
      longint r;
      longint num;
      r   = n - i;
      num = r * r * p0 + 2 * i * r * p1 + i * i * p2;
      return coord_type'(num / (n * n));
   endfunction

   task automatic expand_stroke();
      longint      n;
      longint      p0x, p0y, p1x, p1y, p2x, p2y;
      coord_type   px, py, prev_x, prev_y;
      segment_type seg;
      n = longint'(segment_count_q);
      if (n < 1) n = 1;
      if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
      p0x = halve_sum(req_ch.first_x, req_ch.middle_x);
      p0y = halve_sum(req_ch.first_y, req_ch.middle_y);
      p1x = req_ch.middle_x;
      p1y = req_ch.middle_y;
      p2x = halve_sum(req_ch.middle_x, req_ch.final_x);
      p2y = halve_sum(req_ch.middle_y, req_ch.final_y);
      prev_x = '0;
      prev_y = '0;
      for (longint i = 0; i <= n; i++) begin
         px = curve_sample(p0x, p1x, p2x, n, i);
         py = curve_sample(p0y, p1y, p2y, n, i);
         if (i > 0) begin
            seg.start_x = prev_x;
            seg.start_y = prev_y;
            seg.end_x   = px;
            seg.end_y   = py;
            seg.width   = req_ch.line_width;
            seg.last    = (i == n);
            pending_segments.push_back(seg);
         end
         prev_x = px;
         prev_y = py;
      end
   endtask

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: segment %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_segment();
      segment_type want;
      if (pending_segments.size() == 0) begin
         $display("%0t: segment beat with none expected, actual (%0d,%0d)-(%0d,%0d) w %0d last %0b",
                  $time, rsp_ch.start_x, rsp_ch.start_y, rsp_ch.end_x, rsp_ch.end_y,
                  rsp_ch.width_out, rsp_ch.last_segment);
         mismatch_count++;
      end else begin
         want = pending_segments.pop_front();
         check_field("start_x", want.start_x, rsp_ch.start_x);
         check_field("start_y", want.start_y, rsp_ch.start_y);
         check_field("end_x", want.end_x, rsp_ch.end_x);
         check_field("end_y", want.end_y, rsp_ch.end_y);
         check_field("width_out", want.width, rsp_ch.width_out);
         check_field("last_segment", want.last, rsp_ch.last_segment);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         segment_count_q = SEG_RESET;
         pending_segments.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_segment();
         if (req_ch.valid && req_ch.ready) expand_stroke();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             (csr_paddr >> 2) == REG_SEGMENT_COUNT) begin
            segment_count_q = csr_pwdata[SEG_REG_W-1:0];
         end
      end
      segments_due = pending_segments.size();
   end

endmodule

@@ dv/tb_quadratic_bezier_stroke_segmenter.sv @@
// testbench top: drives strokes, segment_count writes and backpressure, reports the verdict
`timescale 1ns / 1ps
module tb_quadratic_bezier_stroke_segmenter;
   import qbss_pkg::*;

   localparam int RANDOM_STROKES = 96;
   localparam logic [CSR_IDX_W-1:0] UNMAPPED_REG = CSR_IDX_W'(1);

   typedef struct {
      coord_type ax, ay, bx, by, cx, cy;
      line_type  width;
   } stroke_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_SPARSE
   } stall_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatch_count;
   int                    segments_due;
   int                    burst_left;

   qbss_req_if req_ch ();
   qbss_rsp_if rsp_ch ();

   quadratic_bezier_stroke_segmenter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   qbss_segment_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .segments_due   (segments_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // segment receiver, stall pattern changes at random intervals
   initial begin
      stall_mode_type mode;
      int             span;
      rsp_ch.ready = 1'b0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(20, 300);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:  rsp_ch.ready = 1'b1;
               STALL_LIGHT: rsp_ch.ready = ($urandom_range(0, 3) != 0);
               STALL_HEAVY: rsp_ch.ready = ($urandom_range(0, 3) == 0);
               default:     rsp_ch.ready = ($urandom_range(0, 9) == 0);
            endcase
         end
      end
   end

   function automatic stroke_type make_stroke(input int ax, input int ay, input int bx,
                                              input int by, input int cx, input int cy,
                                              input int width);
      stroke_type s;
      s.ax    = coord_type'(ax);
      s.ay    = coord_type'(ay);
      s.bx    = coord_type'(bx);
      s.by    = coord_type'(by);
      s.cx    = coord_type'(cx);
      s.cy    = coord_type'(cy);
      s.width = line_type'(width);
      return s;
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 7))
         0:       return coord_type'(-32768);
         1:       return coord_type'(32767);
         2:       return coord_type'(int'($urandom_range(0, 16)) - 8);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic stroke_type rand_stroke();
      stroke_type s;
      s.ax    = rand_coord();
      s.ay    = rand_coord();
      s.bx    = rand_coord();
      s.by    = rand_coord();
      s.cx    = rand_coord();
      s.cy    = rand_coord();
      s.width = line_type'($urandom);
      return s;
   endfunction

   // mostly short curves, a few long and out-of-range counts
   function automatic seg_type pick_segment_count();
      case ($urandom_range(0, 19))
         0:       return seg_type'(0);
         1:       return seg_type'($urandom_range(65, 127));
         2:       return seg_type'(MAX_SEGMENTS);
         3, 4:    return seg_type'($urandom_range(9, 63));
         default: return seg_type'($urandom_range(1, 8));
      endcase
   endfunction

   // all tasks start and end just after a falling edge
   task automatic send_stroke(input stroke_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 80) : $urandom_range(0, 3);
         repeat (gap) @(negedge clock);
      end
      req_ch.first_x    = s.ax;
      req_ch.first_y    = s.ay;
      req_ch.middle_x   = s.bx;
      req_ch.middle_y   = s.by;
      req_ch.final_x    = s.cx;
      req_ch.final_y    = s.cy;
      req_ch.line_width = s.width;
      req_ch.valid      = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      req_ch.valid = 1'b0;
      burst_left--;
   endtask

   task automatic await_drain();
      req_ch.valid = 1'b0;
      while (segments_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input seg_type value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      // upper data bits random, the register keeps only its own width
      csr_pwdata  = $urandom;
      csr_pwdata[SEG_REG_W-1:0] = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_segments(input seg_type value);
      await_drain();
      write_csr(REG_SEGMENT_COUNT, value);
   endtask

   initial begin
      int sent;
      int phase_len;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.first_x    = '0;
      req_ch.first_y    = '0;
      req_ch.middle_x   = '0;
      req_ch.middle_y   = '0;
      req_ch.final_x    = '0;
      req_ch.final_y    = '0;
      req_ch.line_width = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      burst_left        = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // reset count of 50, all-max, all-min and mixed extreme strokes
      send_stroke(make_stroke(32767, 32767, 32767, 32767, 32767, 32767, 255));
      send_stroke(make_stroke(-32768, -32768, -32768, -32768, -32768, -32768, 0));
      send_stroke(make_stroke(-32768, 32767, 32767, -32768, -32768, 32767, 8'h55));

      // zero count behaves as a single segment from P0 to P2
      set_segments(seg_type'(0));
      send_stroke(make_stroke(-3, -5, 0, 0, 3, 5, 1));
      send_stroke(make_stroke(-32768, -32768, 32767, 32767, -32768, -32768, 8'hAA));

      set_segments(seg_type'(1));
      send_stroke(make_stroke(1, -1, 2, -2, -7, 7, 2));
      send_stroke(make_stroke(32767, -32768, -1, 1, 0, 0, 128));

      // count above the maximum saturates
      set_segments(seg_type'(127));
      send_stroke(make_stroke(-32768, 32767, 32767, -32768, -32768, 32767, 255));

      // write to an unmapped register leaves the count alone
      await_drain();
      write_csr(UNMAPPED_REG, seg_type'(3));
      send_stroke(make_stroke(100, -100, -2000, 3000, -5, 9, 17));

      set_segments(seg_type'(MAX_SEGMENTS));
      send_stroke(make_stroke(-32768, -32768, 32767, 32767, -32768, -32768, 0));

      set_segments(seg_type'(2));
      send_stroke(make_stroke(-1, -1, 0, 0, 1, 1, 3));
      send_stroke(make_stroke(-7, 9, -3, 5, 11, -13, 127));

      set_segments(seg_type'(3));
      send_stroke(make_stroke(-32768, 32767, 0, 0, 32767, -32768, 200));
      send_stroke(make_stroke(-5, -5, -6, -6, -9, -9, 64));

      sent = 0;
      while (sent < RANDOM_STROKES) begin
         set_segments(pick_segment_count());
         if ($urandom_range(0, 5) == 0) begin
            write_csr(UNMAPPED_REG, seg_type'($urandom));
         end
         phase_len = $urandom_range(3, 12);
         for (int k = 0; k < phase_len && sent < RANDOM_STROKES; k++) begin
            if ($urandom_range(0, 9) == 0) await_drain();
            send_stroke(rand_stroke());
            sent++;
         end
      end

      await_drain();
      repeat (1500) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/qbss_pkg.sv
sv/qbss_if.sv
sv/qbss_ctrl.sv
sv/qbss_axis.sv
sv/qbss_datapath.sv
sv/quadratic_bezier_stroke_segmenter.sv
dv/qbss_segment_checker.sv
dv/tb_quadratic_bezier_stroke_segmenter.sv
